### rtl/range_coder_encoder_top_macros.svh
// Assertion helpers for the checker file.
`ifndef RANGE_CODER_ENCODER_TOP_MACROS_SVH
`define RANGE_CODER_ENCODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RCE_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RCE_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rce_pkg.sv
package rce_pkg;

    // Fixed field widths
    localparam int CUM_W   = 17;
    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 64;
    localparam int HALF_W  = 32;
    localparam int LIMIT_W = 32;

    // Partial product of one 32-bit range half by a cum value
    localparam int PP_W  = HALF_W + CUM_W;
    // Full 65-bit range times a cum value
    localparam int SUM_W = WORD_W + 1 + CUM_W;

    // Bytes per interval word, and the emit counter
    localparam int NUM_BYTES = WORD_W / BYTE_W;
    localparam int CNT_W     = $clog2(NUM_BYTES);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NUM_BYTES - 1);

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic REG_BYTE_LIMIT = 1'b0;
    localparam logic [LIMIT_W-1:0] BYTE_LIMIT_RESET = '1;

    // Function codes of an input beat
    localparam logic FUNC_ENCODE = 1'b0;
    localparam logic FUNC_FLUSH  = 1'b1;

    typedef struct packed {
        logic             func;
        logic [CUM_W-1:0] cum_low;
        logic [CUM_W-1:0] cum_high;
    } rce_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last;
        logic              overflow;
    } rce_out_t;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic calc_range;
        logic mul_en;
        logic sel_hi;
        logic sum_en;
        logic upd_high;
        logic upd_low;
        logic emit_byte;
        logic emit_ovf;
        logic last;
        logic shift_enc;
        logic shift_low;
        logic restart;
    } rce_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic agree;
        logic agree_next;
        logic limit_hit;
        logic err;
    } rce_sts_t;

endpackage

### rtl/rce_ctrl.sv
module rce_ctrl
    import rce_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    input  logic     s_func,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  rce_sts_t sts,
    output rce_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RANGE,
        ST_MUL_H,
        ST_MUL_L,
        ST_SUM_L,
        ST_UPD,
        ST_EMIT,
        ST_FLUSH
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;
    logic             enc_last;

    assign out_free = !m_valid_reg || m_ready;
    assign enc_last = (cnt_reg == CNT_LAST) || !sts.agree_next;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and commands
    always_comb begin
        cmd          = '0;
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    cnt_next    = '0;
                    if (s_func == FUNC_FLUSH) begin
                        state_next = ST_FLUSH;
                    end else if (!sts.err) begin
                        state_next = ST_RANGE;
                    end
                end
            end
            ST_RANGE: begin
                cmd.calc_range = 1'b1;
                state_next     = ST_MUL_H;
            end
            ST_MUL_H: begin
                cmd.mul_en = 1'b1;
                cmd.sel_hi = 1'b1;
                state_next = ST_MUL_L;
            end
            ST_MUL_L: begin
                cmd.mul_en = 1'b1;
                cmd.sum_en = 1'b1;
                state_next = ST_SUM_L;
            end
            ST_SUM_L: begin
                cmd.sum_en   = 1'b1;
                cmd.upd_high = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd_low = 1'b1;
                state_next  = ST_EMIT;
            end
            // One agreed top byte per result beat, or an overflow beat at the byte limit
            ST_EMIT: begin
                if (!sts.agree) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sts.limit_hit) begin
                        cmd.emit_ovf = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.emit_byte = 1'b1;
                        cmd.shift_enc = 1'b1;
                        cmd.last      = enc_last;
                        if (enc_last) begin
                            state_next = ST_IDLE;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
            // All bytes of low, ending early in an overflow beat on error or at the byte limit, then restart
            ST_FLUSH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    if (sts.err || sts.limit_hit) begin
                        cmd.emit_ovf = 1'b1;
                        cmd.restart  = 1'b1;
                        state_next   = ST_IDLE;
                    end else begin
                        cmd.emit_byte = 1'b1;
                        cmd.shift_low = 1'b1;
                        cmd.last      = (cnt_reg == CNT_LAST);
                        if (cnt_reg == CNT_LAST) begin
                            cmd.restart = 1'b1;
                            state_next  = ST_IDLE;
                        end else begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### rtl/rce_datapath.sv
module rce_datapath
    import rce_pkg::*;
#(
    parameter int PRECISION_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  rce_cmd_t           cmd,
    input  rce_in_t            in_data,
    input  logic [LIMIT_W-1:0] byte_limit,
    output rce_sts_t           sts,
    output rce_out_t           out_data
);

    // Coder state
    logic [WORD_W-1:0]  low_reg, low_next;
    logic [WORD_W-1:0]  high_reg, high_next;
    logic [LIMIT_W-1:0] sent_reg, sent_next;
    logic               err_reg, err_next;

    // Working registers
    logic [CUM_W-1:0]  cl_reg, ch_reg;
    logic [WORD_W-1:0] range_reg;
    logic              top_reg;
    logic [PP_W-1:0]   pp_lo_reg, pp_mid_reg;
    logic [CUM_W-1:0]  pp_f_reg;
    logic [WORD_W-1:0] scale_reg;
    rce_out_t          out_reg;

    logic [CUM_W-1:0]  f_sel;
    logic [SUM_W-1:0]  prod;

    assign f_sel = cmd.sel_hi ? ch_reg : cl_reg;

    // Recombine the partial products: (top:range) * f, bits above the precision
    assign prod = SUM_W'(pp_lo_reg)
                + (SUM_W'(pp_mid_reg) << HALF_W)
                + (top_reg ? (SUM_W'(pp_f_reg) << WORD_W) : '0);

    assign sts.agree      = (low_reg[WORD_W-1 -: BYTE_W] == high_reg[WORD_W-1 -: BYTE_W]);
    assign sts.agree_next = (low_reg[WORD_W-BYTE_W-1 -: BYTE_W]
                             == high_reg[WORD_W-BYTE_W-1 -: BYTE_W]);
    assign sts.limit_hit  = (sent_reg >= byte_limit);
    assign sts.err        = err_reg;
    assign out_data       = out_reg;

    // Coder state update
    always_comb begin
        low_next  = low_reg;
        high_next = high_reg;
        sent_next = sent_reg;
        err_next  = err_reg;
        if (cmd.upd_high) begin
            high_next = low_reg + scale_reg - WORD_W'(1);
        end
        if (cmd.upd_low) begin
            low_next = low_reg + scale_reg;
        end
        if (cmd.shift_enc) begin
            low_next  = low_reg << BYTE_W;
            high_next = (high_reg << BYTE_W) | WORD_W'({BYTE_W{1'b1}});
        end
        if (cmd.shift_low) begin
            low_next = low_reg << BYTE_W;
        end
        if (cmd.emit_byte) begin
            sent_next = sent_reg + 1'b1;
        end
        if (cmd.emit_ovf) begin
            err_next = 1'b1;
        end
        if (cmd.restart) begin
            low_next  = '0;
            high_next = '1;
            sent_next = '0;
            err_next  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_reg  <= '0;
            high_reg <= '1;
            sent_reg <= '0;
            err_reg  <= 1'b0;
        end else begin
            low_reg  <= low_next;
            high_reg <= high_next;
            sent_reg <= sent_next;
            err_reg  <= err_next;
        end
    end

    // Narrowing pipeline: range, partial products, scaled bound
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cl_reg <= in_data.cum_low;
            ch_reg <= in_data.cum_high;
        end
        if (cmd.calc_range) begin
            range_reg <= high_reg - low_reg + WORD_W'(1);
            top_reg   <= ((high_reg == '1) && (low_reg == '0)) || (high_reg < low_reg);
        end
        if (cmd.mul_en) begin
            pp_lo_reg  <= PP_W'(range_reg[HALF_W-1:0]) * PP_W'(f_sel);
            pp_mid_reg <= PP_W'(range_reg[WORD_W-1:HALF_W]) * PP_W'(f_sel);
            pp_f_reg   <= f_sel;
        end
        if (cmd.sum_en) begin
            scale_reg <= prod[PRECISION_BITS +: WORD_W];
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (cmd.emit_ovf) begin
            out_reg.out_byte <= '0;
            out_reg.last     <= 1'b1;
            out_reg.overflow <= 1'b1;
        end else if (cmd.emit_byte) begin
            out_reg.out_byte <= low_reg[WORD_W-1 -: BYTE_W];
            out_reg.last     <= cmd.last;
            out_reg.overflow <= 1'b0;
        end
    end

endmodule

### rtl/range_coder_encoder_top.sv
// Range coder encoder, 64-bit low/high interval.
// Input channel s_*: one beat per symbol (func = encode, cum_low/cum_high
// bounds) or per flush (func = flush, cum fields ignored).
// Result channel m_*: one code byte per beat; last marks the final beat of
// an input beat, overflow marks a byte-limit violation (out_byte is zero).
// APB port: byte_limit at address 0, reset all ones, write only while idle.
// Flow: an encode beat passes the narrowing states (range, two multiply
// steps on the 32x17 multiplier pair, two adds), then emits 0 to 8 bytes
// at one per cycle while m_ready allows; s_ready returns after the last
// one. A flush emits all 8 bytes of low, or stops with an overflow beat
// when an earlier error or the byte limit stops it.
// Throughput is set by the shared multiplier pair and the one-byte shifter.
// The result register frees the emitter as soon as the receiver takes a
// beat; while m_ready is low the pending beat holds and the emitter waits.
// A new input beat is taken while the last result still waits.
// Reset (aresetn low, synchronous): full interval state, no error,
// byte count zero, byte_limit all ones, no result pending.
module range_coder_encoder_top
    import rce_pkg::*;
#(
    parameter int PRECISION_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rce_in_t               s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rce_out_t              m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [LIMIT_W-1:0] byte_limit_reg;
    logic               reg_idx;
    rce_cmd_t           cmd;
    rce_sts_t           sts;

    assign pready  = 1'b1;
    assign reg_idx = paddr[CFG_ADDR_W-1];

    // Register write
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_limit_reg <= BYTE_LIMIT_RESET;
        end else if (psel && penable && pwrite && (reg_idx == REG_BYTE_LIMIT)) begin
            byte_limit_reg <= pwdata[LIMIT_W-1:0];
        end
    end

    // Register read
    always_comb begin
        prdata = '0;
        if (reg_idx == REG_BYTE_LIMIT) begin
            prdata = CFG_DATA_W'(byte_limit_reg);
        end
    end

    rce_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    rce_datapath #(
        .PRECISION_BITS (PRECISION_BITS)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .in_data    (s_data),
        .byte_limit (byte_limit_reg),
        .sts        (sts),
        .out_data   (m_data)
    );

endmodule

### rtl/rce_checker.sv
`include "range_coder_encoder_top_macros.svh"

module rce_checker
    import rce_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_valid,
    input logic                  s_ready,
    input rce_in_t               s_data,
    input logic                  m_valid,
    input logic                  m_ready,
    input rce_out_t              m_data,
    input logic                  psel,
    input logic                  penable,
    input logic                  pwrite,
    input logic [CFG_ADDR_W-1:0] paddr,
    input logic [CFG_DATA_W-1:0] pwdata,
    input logic [CFG_DATA_W-1:0] prdata,
    input logic                  pready
);

    // A stalled result beat holds
    `RCE_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result beat changed while stalled")

    // Overflow beats carry a zero byte and end the item
    `RCE_ASSERT_IMP(a_ovf_form, aclk, aresetn, m_valid && m_data.overflow, (m_data.out_byte == '0) && m_data.last, "malformed overflow beat")

    // A flush always produces output, so the input side closes next cycle
    `RCE_ASSERT_NXT(a_flush_busy, aclk, aresetn, s_valid && s_ready && (s_data.func == FUNC_FLUSH), !s_ready, "input ready right after a flush beat")

    // No new input while an item's bytes are still coming
    `RCE_ASSERT_IMP(a_mid_item, aclk, aresetn, m_valid && !m_data.last, !s_ready, "input ready in the middle of an item")

endmodule

bind range_coder_encoder_top rce_checker u_rce_checker (.*);

### verif/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rce_pkg::*;

    localparam int          PREC           = 16;
    localparam int          CLK_PERIOD     = 10;
    localparam int          RESET_CYCLES   = 4;
    // encode narrowing plus a full 8-byte emit, with margin
    localparam int          SETTLE_CYCLES  = 24;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [15:0] READY_PATTERN  = 16'hB6E5;
    localparam logic [CFG_ADDR_W-1:0] LIMIT_ADDR = CFG_ADDR_W'(4 * REG_BYTE_LIMIT);
    localparam rce_out_t    OVERFLOW_BEAT  = '{out_byte: '0, last: 1'b1, overflow: 1'b1};

    // DUT signals
    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    rce_in_t               s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    rce_out_t              m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [CFG_DATA_W-1:0] pwdata  = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // stimulus and expected code bytes
    rce_in_t     pending_q[$];
    rce_out_t    code_beats_q[$];
    rce_out_t    want;
    int unsigned error_cnt = 0;

    // coder model state
    logic [WORD_W-1:0]  coder_low  = '0;
    logic [WORD_W-1:0]  coder_high = '1;
    logic [LIMIT_W-1:0] coder_sent = '0;
    logic               coder_err  = 1'b0;
    logic [LIMIT_W-1:0] byte_limit = BYTE_LIMIT_RESET;

    // sender / receiver pacing
    int unsigned burst_left  = 0;
    int unsigned gap_left    = 0;
    int unsigned ready_mode  = 0;
    int unsigned ready_tick  = 0;
    int unsigned idle_cycles = 0;

    range_coder_encoder_top #(
        .PRECISION_BITS(PREC)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    // ---------------------------------------------------------------
    // Coder model
    // ---------------------------------------------------------------
    function automatic void restart_coder();
        coder_low  = '0;
        coder_high = '1;
        coder_sent = '0;
        coder_err  = 1'b0;
    endfunction

    // one byte out, or the overflow beat once the limit is reached
    function automatic rce_out_t send_byte(input logic [BYTE_W-1:0] b);
        rce_out_t r;
        if (coder_sent >= byte_limit) begin
            r = OVERFLOW_BEAT;
            coder_err = 1'b1;
        end else begin
            r = '{out_byte: b, last: 1'b0, overflow: 1'b0};
            coder_sent++;
        end
        return r;
    endfunction

    function automatic void encode_beat(input rce_in_t beat);
        rce_out_t          beats[$];
        rce_out_t          r;
        logic [WORD_W:0]   span;
        logic [81:0]       prod_hi;
        logic [81:0]       prod_lo;
        logic [WORD_W-1:0] base;
        logic              top;
        logic              stop;
        stop = 1'b0;
        if (beat.func == FUNC_FLUSH) begin
            if (coder_err) begin
                beats.push_back(OVERFLOW_BEAT);
            end else begin
                for (int i = 0; i < NUM_BYTES && !stop; i++) begin
                    r = send_byte(coder_low[WORD_W-1 -: BYTE_W]);
                    beats.push_back(r);
                    stop = r.overflow;
                    coder_low = coder_low << BYTE_W;
                end
            end
            restart_coder();
        end else if (!coder_err) begin
            // narrow: 65-bit range, bit 64 set on a full range or a wrapped one
            top     = (coder_high == '1 && coder_low == '0) || (coder_high < coder_low);
            span    = {top, coder_high - coder_low + 64'd1};
            prod_hi = span * beat.cum_high;
            prod_lo = span * beat.cum_low;
            base    = coder_low;
            coder_high = base + prod_hi[PREC +: WORD_W] - 64'd1;
            coder_low  = base + prod_lo[PREC +: WORD_W];
            // shift out every settled top byte
            for (int i = 0; i < NUM_BYTES && !stop &&
                 coder_low[WORD_W-1 -: BYTE_W] == coder_high[WORD_W-1 -: BYTE_W]; i++) begin
                r = send_byte(coder_low[WORD_W-1 -: BYTE_W]);
                beats.push_back(r);
                stop = r.overflow;
                if (!stop) begin
                    coder_low  = coder_low << BYTE_W;
                    coder_high = {coder_high[WORD_W-BYTE_W-1:0], 8'hFF};
                end
            end
        end
        foreach (beats[i]) begin
            r = beats[i];
            if (i == beats.size() - 1)
                r.last = 1'b1;
            code_beats_q.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic rce_in_t make_beat(input logic fn, input int unsigned cl,
                                          input int unsigned ch);
        rce_in_t b;
        b.func     = fn;
        b.cum_low  = CUM_W'(cl);
        b.cum_high = CUM_W'(ch);
        return b;
    endfunction

    // well-formed symbol; narrow widths make bytes settle quickly
    function automatic rce_in_t rand_symbol();
        int unsigned w;
        int unsigned cl;
        case ($urandom_range(0, 3))
            0: w = $urandom_range(1, 16);
            1: w = $urandom_range(1, 1024);
            2: w = $urandom_range(1024, 65536);
            default: w = $urandom_range(1, 65536);
        endcase
        cl = $urandom_range(0, 65536 - w);
        return make_beat(FUNC_ENCODE, cl, cl + w);
    endfunction

    function automatic rce_in_t rand_noise();
        return make_beat(($urandom_range(0, 3) == 0) ? FUNC_FLUSH : FUNC_ENCODE,
                         $urandom, $urandom);
    endfunction

    // messages of random symbols closed by a flush, with stray beats between
    task automatic queue_messages(input int unsigned n);
        int unsigned added;
        int unsigned len;
        added = 0;
        while (added < n) begin
            if ($urandom_range(0, 7) == 0) begin
                pending_q.push_back(rand_noise());
                added++;
            end else begin
                len = $urandom_range(1, 12);
                repeat (len) pending_q.push_back(rand_symbol());
                pending_q.push_back(make_beat(FUNC_FLUSH, $urandom, $urandom));
                added += len + 1;
            end
        end
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LIMIT_ADDR;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        byte_limit = value;
    endtask

    // all beats in and all code bytes out, then let the block settle
    task automatic wait_idle();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_valid || code_beats_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ---------------------------------------------------------------
    // Sequence
    // ---------------------------------------------------------------
    initial begin
        logic [LIMIT_W-1:0] phase_limit;
        int unsigned        phase_items;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // bounds at the edges, empty and inverted intervals, flush
        write_limit('1);
        pending_q.push_back(make_beat(FUNC_ENCODE, 0, 65536));
        pending_q.push_back(make_beat(FUNC_ENCODE, 0, 1));
        pending_q.push_back(make_beat(FUNC_ENCODE, 65535, 65536));
        pending_q.push_back(make_beat(FUNC_ENCODE, 65536, 65536));
        pending_q.push_back(make_beat(FUNC_ENCODE, 65536, 65536));
        pending_q.push_back(make_beat(FUNC_ENCODE, 40000, 100));
        pending_q.push_back(make_beat(FUNC_ENCODE, 131071, 131071));
        pending_q.push_back(make_beat(FUNC_ENCODE, 0, 0));
        pending_q.push_back(make_beat(FUNC_ENCODE, 131071, 0));
        pending_q.push_back(make_beat(FUNC_FLUSH, 131071, 131071));
        pending_q.push_back(make_beat(FUNC_ENCODE, 1, 2));
        pending_q.push_back(make_beat(FUNC_FLUSH, 0, 0));
        wait_idle();

        // zero limit: overflow on encode, a silent encode, an overflow beat on a flush
        // in error, then overflow on the first flush byte
        write_limit('0);
        pending_q.push_back(make_beat(FUNC_ENCODE, 0, 1));
        pending_q.push_back(make_beat(FUNC_ENCODE, 0, 1));
        pending_q.push_back(make_beat(FUNC_FLUSH, 0, 0));
        pending_q.push_back(make_beat(FUNC_FLUSH, 0, 0));
        wait_idle();

        // limit hit part way through a flush
        write_limit(32'd3);
        pending_q.push_back(make_beat(FUNC_ENCODE, 0, 1));
        pending_q.push_back(make_beat(FUNC_FLUSH, 0, 0));
        wait_idle();

        // random messages under several limits
        for (int p = 0; p < 4; p++) begin
            case (p)
                0: begin phase_limit = $urandom_range(4, 40);  phase_items = 40; end
                1: begin phase_limit = '1;                     phase_items = 50; end
                2: begin phase_limit = $urandom_range(1, 3);   phase_items = 15; end
                default: begin phase_limit = $urandom_range(16, 200); phase_items = 30; end
            endcase
            write_limit(phase_limit);
            queue_messages(phase_items);
            wait_idle();
        end

        if (error_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ---------------------------------------------------------------
    // Driver: bursts of beats with random gaps
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (gap_left != 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_q.size() != 0) begin
                s_valid <= 1'b1;
                s_data  <= pending_q.pop_front();
                if (burst_left != 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 16);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Monitor: predict on accepted input, check each result beat
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            restart_coder();
            m_ready <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                encode_beat(s_data);

            if (m_valid && m_ready) begin
                if (code_beats_q.size() == 0) begin
                    error_cnt++;
                    $error("unexpected beat: out_byte %0h last %0b overflow %0b",
                           m_data.out_byte, m_data.last, m_data.overflow);
                end else begin
                    want = code_beats_q.pop_front();
                    if (m_data.out_byte !== want.out_byte) begin
                        error_cnt++;
                        $error("out_byte: expected %0h, actual %0h",
                               want.out_byte, m_data.out_byte);
                    end
                    if (m_data.last !== want.last) begin
                        error_cnt++;
                        $error("last: expected %0b, actual %0b", want.last, m_data.last);
                    end
                    if (m_data.overflow !== want.overflow) begin
                        error_cnt++;
                        $error("overflow: expected %0b, actual %0b",
                               want.overflow, m_data.overflow);
                    end
                end
            end

            // receiver stalls: one of four ready modes, picked at random
            ready_tick++;
            if (ready_tick % 64 == 0)
                ready_mode = $urandom_range(0, 3);
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= $urandom_range(0, 1);
                2: m_ready <= ($urandom_range(0, 7) != 0);
                default: m_ready <= READY_PATTERN[ready_tick[3:0]];
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: cycles without any accepted beat or register write
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

endmodule
